### sv/deq_pkg.sv
package deq_pkg;

  // operation codes on the request channel
  localparam int unsigned OpW = 3;
  localparam logic [OpW-1:0] OP_DUMP       = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd4;

  // status codes on the result channel
  localparam int unsigned StW = 2;
  localparam logic [StW-1:0] ST_OK         = 2'd0;
  localparam logic [StW-1:0] ST_FULL       = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY_POP  = 2'd2;
  localparam logic [StW-1:0] ST_EMPTY_DUMP = 2'd3;

  // per-cycle move applied to every cell of the row
  typedef enum logic [2:0] {
    MV_HOLD,
    MV_PUSH_FRONT,
    MV_PUSH_BACK,
    MV_POP_FRONT,
    MV_ROTATE
  } move_e;

endpackage

### sv/deq_if.sv
interface deq_req_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::OpW-1:0]     operation;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 7
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] element;
  logic                          last;
  logic [deq_pkg::StW-1:0]       status;
  logic [CNT_W-1:0]              count;

  modport source (output valid, output element, output last, output status, output count,
                  input ready);
  modport sink   (input valid, input element, input last, input status, input count,
                  output ready);
endinterface

### sv/deq_cell.sv
module deq_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                   clk_i,
  input  deq_pkg::move_e         move_i,
  input  logic [CNT_W-1:0]       held_i,
  input  logic [VALUE_WIDTH-1:0] push_value_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic [VALUE_WIDTH-1:0] head_i,
  output logic [VALUE_WIDTH-1:0] data_o
);

  localparam logic [CNT_W-1:0] IdxC  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NextC = CNT_W'(IDX + 1);

  logic [VALUE_WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (move_i)
      deq_pkg::MV_PUSH_FRONT: data_d = (IDX == 0) ? push_value_i : left_i;
      deq_pkg::MV_PUSH_BACK: begin
        if (held_i == IdxC) data_d = push_value_i;
      end
      deq_pkg::MV_POP_FRONT: data_d = right_i;
      deq_pkg::MV_ROTATE: begin
        // tail cell takes the old front, cells ahead of it move one step up
        if (held_i == NextC) begin
          data_d = head_i;
        end else if (NextC < held_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### sv/double_ended_queue.sv
// Bounded double-ended queue of signed words held in a row of cells.
// Cell 0 always holds the front element; element k sits in cell k.
//
// Channels: req_i (sink) carries operation and value; rsp_o (source) carries
// element, last, status and count. Both use valid/ready; a beat moves when
// both are high.
//
// Push and pop: one result beat, registered, available the cycle after the
// request beat. A new request is taken each cycle while the result register
// is empty or is being drained, so pushes and pops run at one per cycle.
// Dump: held result beats (held = elements in the queue), front to back,
// last marked, one per cycle while the receiver takes them; an empty dump
// gives a single status beat. The row rotates one place per beat, so after
// the dump the order is restored, and req_i is blocked until the last beat.
// Unknown operation codes are taken and dropped without a result.
//
// Reset clears the element count, the dump sequencer and the result valid
// flag; cell contents are not reset. When the receiver stalls, the
// result register holds its beat, the row stops and req_i.ready drops.
module double_ended_queue #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic       ST_IDLE = 1'b0;
  localparam logic       ST_DUMP = 1'b1;
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] OneC = CNT_W'(1);

  logic                   state_d, state_q;
  logic [CNT_W-1:0]       held_d, held_q;
  logic [CNT_W-1:0]       idx_d, idx_q;

  logic                   out_valid_d, out_valid_q;
  logic [VALUE_WIDTH-1:0] out_elem_d, out_elem_q;
  logic                   out_last_d, out_last_q;
  logic [deq_pkg::StW-1:0] out_status_d, out_status_q;
  logic [CNT_W-1:0]       out_count_d, out_count_q;

  logic                   slot_free, req_acc, load_out;
  deq_pkg::move_e         move;

  logic [VALUE_WIDTH-1:0] cell_data [CAPACITY];
  logic [VALUE_WIDTH-1:0] push_value;

  assign push_value = req_i.value;
  assign slot_free  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && slot_free;
  assign req_acc    = req_i.valid && req_i.ready;

  // control: pick the row move and the result beat
  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    idx_d        = idx_q;
    move         = deq_pkg::MV_HOLD;
    load_out     = 1'b0;
    out_elem_d   = '0;
    out_last_d   = 1'b1;
    out_status_d = deq_pkg::ST_OK;

    if (state_q == ST_IDLE) begin
      if (req_acc) begin
        case (req_i.operation)
          deq_pkg::OP_DUMP: begin
            if (held_q == '0) begin
              load_out     = 1'b1;
              out_status_d = deq_pkg::ST_EMPTY_DUMP;
            end else begin
              state_d = ST_DUMP;
              idx_d   = '0;
            end
          end
          deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
            load_out = 1'b1;
            if (held_q == CapC) begin
              out_status_d = deq_pkg::ST_FULL;
            end else begin
              move   = (req_i.operation == deq_pkg::OP_PUSH_FRONT) ?
                       deq_pkg::MV_PUSH_FRONT : deq_pkg::MV_PUSH_BACK;
              held_d = held_q + OneC;
            end
          end
          deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
            load_out = 1'b1;
            if (held_q == '0) begin
              out_status_d = deq_pkg::ST_EMPTY_POP;
            end else begin
              // pop at the back only shrinks the count
              if (req_i.operation == deq_pkg::OP_POP_FRONT) move = deq_pkg::MV_POP_FRONT;
              held_d = held_q - OneC;
            end
          end
          default: ;
        endcase
      end
    end else if (slot_free) begin
      // dump: stream cell 0, rotate the occupied part of the row
      load_out   = 1'b1;
      move       = deq_pkg::MV_ROTATE;
      out_elem_d = cell_data[0];
      out_last_d = (idx_q == held_q - OneC);
      idx_d      = idx_q + OneC;
      if (out_last_d) state_d = ST_IDLE;
    end

    out_count_d = held_d;

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_elem_q   <= out_elem_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.element = out_elem_q;
  assign rsp_o.last    = out_last_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.count   = out_count_q;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = push_value;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_lastc
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    deq_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .move_i       (move),
      .held_i       (held_q),
      .push_value_i (push_value),
      .left_i       (left_w),
      .right_i      (right_w),
      .head_i       (cell_data[0]),
      .data_o       (cell_data[i])
    );
  end

  // checks
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CapC)
    else $error("element count above capacity");

  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> idx_q < held_q)
    else $error("dump index past tail");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && load_out && out_last_d) |=> state_q == ST_IDLE)
    else $error("dump did not end after last beat");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.operation == deq_pkg::OP_PUSH_BACK && held_q != CapC)
    |=> held_q == $past(held_q) + OneC)
    else $error("push back did not grow the queue");

endmodule
